// ===== hw/rtl/area_average_row_scaler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Area average row scaler - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef AREA_AVERAGE_ROW_SCALER_CORE_MACROS_SVH
`define AREA_AVERAGE_ROW_SCALER_CORE_MACROS_SVH

// Same-cycle implication.
`define AARS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AARS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/aars_pkg.sv =====
// ----------------------------------------------------------------------------
// aars_pkg
// Types and fixed widths shared by the area average row scaler modules.
// ----------------------------------------------------------------------------
package aars_pkg;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 12;
  localparam int CNT_W       = 13;
  localparam int SCALE_W     = 17;
  localparam int RESULT_CAP  = 64;
  localparam int CAP_W       = 7;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_SCALE = 1'b0;
  localparam logic [PADDR_W-3:0] REG_WIDTH = 1'b1;

  localparam logic [CNT_W-1:0] WIDTH_RESET = 13'd1;

  typedef enum logic {
    KIND_PIXEL,
    KIND_ROW_END
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_STRETCH,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    item_kind_t       kind;
  } queue_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] column;
  } result_t;

  typedef struct packed {
    logic push;
    logic finish;
    logic row_end;
  } res_ctrl_t;

endpackage

// ===== hw/rtl/area_average_row_scaler_core.sv =====
// ----------------------------------------------------------------------------
// area_average_row_scaler_core
// Horizontal area-average resampler for one RGB row at a time, with APB
// registers for scale factor and output width.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   in_red, in_green, in_blue, row_last
//   output    out_valid / out_stall out_red, out_green, out_blue,
//                                   out_column, run_last, row_end
//   config    APB (psel, penable)   paddr, pwdata, prdata
//
// An item is popped, closes the output columns its fraction fills and folds
// the remainder; a row-end item then stretches its last pixel to the width.
// The shared multiply-accumulate in the sequencer does this, one column per
// cycle unless stalled. A two-entry queue takes input while the sequencer runs.
// Reset is synchronous: scale 1.0, width 1, row state empty, no sweep.
// Output stall holds the sequencer once its result stage is full.
// ----------------------------------------------------------------------------
module area_average_row_scaler_core import aars_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int SCALE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_red,
  input  logic [PIX_W-1:0]   in_green,
  input  logic [PIX_W-1:0]   in_blue,
  input  logic               row_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_red,
  output logic [PIX_W-1:0]   out_green,
  output logic [PIX_W-1:0]   out_blue,
  output logic [COL_W-1:0]   out_column,
  output logic               run_last,
  output logic               row_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [SCALE_W-1:0] ScaleReset = SCALE_W'(1 << SCALE_BITS);

  logic [SCALE_W-1:0] scale_factor;
  logic [CNT_W-1:0]   output_width;
  logic               cfg_write;
  logic               head_valid;
  queue_item_t        head;
  logic               pop;
  result_t            res;
  res_ctrl_t          ctrl;
  logic               slot_ok;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= ScaleReset;
      output_width <= WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[PADDR_W-1:2])
        REG_SCALE: scale_factor <= pwdata[SCALE_W-1:0];
        REG_WIDTH: output_width <= pwdata[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_SCALE: prdata = PDATA_W'(scale_factor);
      REG_WIDTH: prdata = PDATA_W'(output_width);
      default:   prdata = '0;
    endcase
  end

  aars_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .row_last  (row_last),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  aars_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .SCALE_BITS(SCALE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .scale_factor(scale_factor),
    .output_width(output_width),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .res         (res),
    .ctrl        (ctrl),
    .slot_ok     (slot_ok)
  );

  aars_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .ctrl      (ctrl),
    .slot_ok   (slot_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_column(out_column),
    .run_last  (run_last),
    .row_end   (row_end)
  );

endmodule

// ===== hw/rtl/aars_front.sv =====
// ----------------------------------------------------------------------------
// aars_front
// Accepts input pixels, tags each as mid-row or row end, and queues them
// for the back-end sequencer.
// ----------------------------------------------------------------------------
module aars_front import aars_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  input  logic             row_last,
  output logic             head_valid,
  output queue_item_t      head,
  input  logic             pop
);

  queue_item_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  queue_item_t       item;

  assign in_stall   = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_comb begin
    item.red   = in_red;
    item.green = in_green;
    item.blue  = in_blue;
    item.kind  = row_last ? KIND_ROW_END : KIND_PIXEL;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aars_out.sv =====
// ----------------------------------------------------------------------------
// aars_out
// Result stage: holds the newest column until the next one or the end of
// the item shows whether it closes the run, then registers it onto the port.
// ----------------------------------------------------------------------------
module aars_out import aars_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  result_t          res,
  input  res_ctrl_t        ctrl,
  output logic             slot_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output logic [COL_W-1:0] out_column,
  output logic             run_last,
  output logic             row_end
);

  logic    pend_valid;
  result_t pend;
  logic    out_free;
  logic    load_out;

  assign out_free = !out_valid || !out_stall;
  assign slot_ok  = !pend_valid || out_free;
  assign load_out = pend_valid && (ctrl.push || ctrl.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.push) begin
        pend_valid <= 1'b1;
      end else if (ctrl.finish) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      pend <= res;
    end
    if (load_out) begin
      out_red    <= pend.red;
      out_green  <= pend.green;
      out_blue   <= pend.blue;
      out_column <= pend.column;
      run_last   <= ctrl.finish;
      row_end    <= ctrl.finish && ctrl.row_end;
    end
  end

endmodule

// ===== hw/rtl/aars_back.sv =====
// ----------------------------------------------------------------------------
// aars_back
// Sequencer: closes one output column per cycle unless stalled, through a
// shared multiply-accumulate, folds the remainder into the accumulators, and
// on a row end stretches the last pixel toward the output width.
// ----------------------------------------------------------------------------
module aars_back import aars_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int SCALE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCALE_W-1:0] scale_factor,
  input  logic [CNT_W-1:0]   output_width,
  input  logic               head_valid,
  input  queue_item_t        head,
  output logic               pop,
  output result_t            res,
  output res_ctrl_t          ctrl,
  input  logic               slot_ok
);

  localparam int SumW  = SCALE_BITS + PIX_W;
  localparam int FracW = SCALE_BITS + 1;
  localparam int TotW  = SumW + 1;
  localparam logic [FracW-1:0] FullFrac = {1'b1, {SCALE_BITS{1'b0}}};
  localparam logic [FracW-1:0] HalfFrac = {2'b01, {(SCALE_BITS-1){1'b0}}};

  back_state_t        state;
  back_state_t        state_next;
  logic [PIX_W-1:0]   pix [3];
  logic               last_r;
  logic [SCALE_W-1:0] left;
  logic [FracW-1:0]   fill;
  logic [SumW-1:0]    sum [3];
  logic [CNT_W-1:0]   columns_done;
  logic [CAP_W-1:0]   n_res;

  logic [CNT_W-1:0]   wlim;
  logic               can_close;
  logic               emit_open;
  logic               emit;
  logic               advance;
  logic [FracW-1:0]   frac;
  logic [FracW-1:0]   bias;
  logic [TotW-1:0]    prod  [3];
  logic [TotW-1:0]    total [3];

  // Datapath: one column close, stretch column or remainder fold per cycle unless stalled
  always_comb begin
    if (int'(output_width) > MAX_WIDTH) begin
      wlim = CNT_W'(MAX_WIDTH);
    end else begin
      wlim = output_width;
    end
    can_close = (left >= SCALE_W'(fill));
    emit_open = (columns_done < wlim) && (n_res < CAP_W'(RESULT_CAP));
    frac = (state == ST_CLOSE && !can_close) ? left[FracW-1:0] : fill;
    bias = (state == ST_STRETCH) ? HalfFrac : '0;
    for (int c = 0; c < 3; c++) begin
      prod[c]  = TotW'(frac) * TotW'(pix[c]);
      total[c] = TotW'(sum[c]) + prod[c] + TotW'(bias);
    end
    res.red    = total[0][SCALE_BITS+PIX_W-1:SCALE_BITS];
    res.green  = total[1][SCALE_BITS+PIX_W-1:SCALE_BITS];
    res.blue   = total[2][SCALE_BITS+PIX_W-1:SCALE_BITS];
    res.column = columns_done[COL_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (!can_close) state_next = last_r ? ST_STRETCH : ST_FINISH;
      end
      ST_STRETCH: begin
        if (!emit_open) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_ok) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == ST_IDLE) && head_valid;
    emit         = ((state == ST_CLOSE && can_close) || state == ST_STRETCH) && emit_open;
    advance      = !emit || slot_ok;
    ctrl.push    = emit && slot_ok;
    ctrl.finish  = (state == ST_FINISH) && slot_ok;
    ctrl.row_end = last_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix[0] <= head.red;
      pix[1] <= head.green;
      pix[2] <= head.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_r       <= 1'b0;
      left         <= '0;
      fill         <= FullFrac;
      columns_done <= '0;
      n_res        <= '0;
      for (int c = 0; c < 3; c++) sum[c] <= '0;
    end else if (pop) begin
      last_r <= (head.kind == KIND_ROW_END);
      left   <= scale_factor;
      n_res  <= '0;
    end else if (state == ST_CLOSE && advance) begin
      if (can_close) begin
        // Column full: close it, accumulators restart
        left <= left - SCALE_W'(fill);
        fill <= FullFrac;
        for (int c = 0; c < 3; c++) sum[c] <= '0;
        if (emit) begin
          columns_done <= columns_done + CNT_W'(1);
          n_res        <= n_res + CAP_W'(1);
        end
      end else begin
        fill <= fill - left[FracW-1:0];
        for (int c = 0; c < 3; c++) sum[c] <= total[c][SumW-1:0];
      end
    end else if (state == ST_STRETCH && advance) begin
      fill <= FullFrac;
      for (int c = 0; c < 3; c++) sum[c] <= '0;
      if (emit_open) begin
        columns_done <= columns_done + CNT_W'(1);
        n_res        <= n_res + CAP_W'(1);
      end else begin
        // Row done: start the next one empty
        columns_done <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/aars_checker.sv =====
// ----------------------------------------------------------------------------
// aars_checker
// Port-level checks on the area average row scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "area_average_row_scaler_core_macros.svh"

module aars_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [11:0] out_column,
  input logic        run_last,
  input logic        row_end,
  input logic        psel,
  input logic [31:0] prdata
);

  // Hold a stalled output transaction
  `AARS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_column) && $stable(run_last) && $stable(row_end), "stalled output changed")

  // The row's final pixel also ends its run
  `AARS_ASSERT(a_row_end_run, out_valid && row_end, run_last, "row_end without run_last")

  // Register reads carry no bits above the widest register
  `AARS_ASSERT(a_prdata_pad, psel, prdata[31:17] == 15'd0, "prdata upper bits set")

endmodule

bind area_average_row_scaler_core aars_checker u_aars_checker (.*);

// ===== bench/tb_area_average_row_scaler_core.sv =====
// ----------------------------------------------------------------------------
// tb_area_average_row_scaler_core
// Self-checking bench for the area average row scaler. A directed table
// runs first, with hand-written results where they are obvious. Random rows
// follow under changing scale and width settings and several idle/stall
// mixes, including a long output hold-off. Every output column is checked
// against a local fixed-point resampler or a hand-written result, in order.
// ----------------------------------------------------------------------------
module tb_area_average_row_scaler_core import aars_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLUMNS   = 4096;
  localparam int unsigned SCALE_SHIFT   = 12;
  localparam int unsigned FULL_FRAC     = 4096;
  localparam int unsigned HALF_FRAC     = 2048;
  localparam int unsigned SCALE_RESET   = 4096;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] column;
    logic             run_last;
    logic             row_end;
  } pix_result_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_SCALE, ROW_WIDTH} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
    check_t      chk;
    pix_result_t want;
  } stim_row_t;

  localparam pix_result_t NO_COL = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_red = '0;
  logic [PIX_W-1:0]   in_green = '0;
  logic [PIX_W-1:0]   in_blue = '0;
  logic               row_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   out_red;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_blue;
  logic [COL_W-1:0]   out_column;
  logic               run_last;
  logic               row_end;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Resampler state and register shadow
  logic [19:0]       acc_red = '0;
  logic [19:0]       acc_green = '0;
  logic [19:0]       acc_blue = '0;
  int unsigned       fill_frac = FULL_FRAC;
  int unsigned       cols_done = 0;
  logic [SCALE_W-1:0] cfg_scale = SCALE_W'(SCALE_RESET);
  logic [CNT_W-1:0]  cfg_width = WIDTH_RESET;

  pix_result_t step_cols[$];
  pix_result_t pending_cols[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_request = 1'b0;
  logic hold_active = 1'b0;

  stim_row_t directed_rows [28] = '{
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd0, 8'd170, 1'b0, CHK_ONE,
      '{8'd255, 8'd0, 8'd170, 12'd0, 1'b1, 1'b0}},
    // column beyond width 1, so the row ends silently
    '{ROW_PIXEL, 32'd0, 8'd0, 8'd255, 8'd85, 1'b1, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd1, 8'd2, 8'd3, 1'b1, CHK_ONE,
      '{8'd1, 8'd2, 8'd3, 12'd0, 1'b1, 1'b1}},
    '{ROW_WIDTH, 32'd8, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_SCALE, 32'd1536, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd200, 8'd100, 8'd50, 1'b0, CHK_MODEL, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd255, 8'd255, 1'b0, CHK_MODEL, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, CHK_MODEL, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd17, 8'd34, 8'd51, 1'b1, CHK_MODEL, NO_COL},
    '{ROW_SCALE, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd255, 8'd255, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd90, 8'd180, 8'd45, 1'b1, CHK_MODEL, NO_COL},
    '{ROW_SCALE, 32'd131071, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_WIDTH, 32'd8191, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd0, 8'd255, 1'b0, CHK_MODEL, NO_COL},
    // hits the per-item result cap during the stretch
    '{ROW_PIXEL, 32'd0, 8'd10, 8'd20, 8'd30, 1'b1, CHK_MODEL, NO_COL},
    '{ROW_WIDTH, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_SCALE, 32'd4096, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd255, 8'd255, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd128, 8'd64, 8'd32, 1'b1, CHK_NONE, NO_COL},
    '{ROW_SCALE, 32'd1, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_WIDTH, 32'd3, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd255, 8'd255, 1'b0, CHK_MODEL, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd255, 8'd255, 8'd255, 1'b1, CHK_MODEL, NO_COL},
    '{ROW_SCALE, 32'd10000, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_WIDTH, 32'd4, 8'd0, 8'd0, 8'd0, 1'b0, CHK_NONE, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd77, 8'd88, 8'd99, 1'b0, CHK_MODEL, NO_COL},
    '{ROW_PIXEL, 32'd0, 8'd1, 8'd254, 8'd128, 1'b1, CHK_MODEL, NO_COL}
  };

  area_average_row_scaler_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .row_last   (row_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_column (out_column),
    .run_last   (run_last),
    .row_end    (row_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  function automatic int unsigned col_limit();
    return (cfg_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_width);
  endfunction

  // Close one column; columns past the width or the cap are computed but dropped.
  function automatic void close_column(input int unsigned frac, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       input int unsigned bias);
    pix_result_t col;
    col.red      = 8'((acc_red + frac * r + bias) >> SCALE_SHIFT);
    col.green    = 8'((acc_green + frac * g + bias) >> SCALE_SHIFT);
    col.blue     = 8'((acc_blue + frac * b + bias) >> SCALE_SHIFT);
    col.column   = COL_W'(cols_done);
    col.run_last = 1'b0;
    col.row_end  = 1'b0;
    acc_red   = '0;
    acc_green = '0;
    acc_blue  = '0;
    if (cols_done < col_limit() && step_cols.size() < RESULT_CAP) begin
      step_cols.push_back(col);
      cols_done = cols_done + 1;
    end
  endfunction

  function automatic void resample_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic last);
    int unsigned left;
    pix_result_t tail;
    step_cols.delete();
    left = cfg_scale;
    while (left >= fill_frac) begin
      close_column(fill_frac, r, g, b, 0);
      left -= fill_frac;
      fill_frac = FULL_FRAC;
    end
    if (left > 0) begin
      acc_red   = 20'(acc_red + left * r);
      acc_green = 20'(acc_green + left * g);
      acc_blue  = 20'(acc_blue + left * b);
      fill_frac -= left;
    end
    if (last) begin
      // stretch the last pixel out to the row width, rounded
      while (cols_done < col_limit() && step_cols.size() < RESULT_CAP) begin
        close_column(fill_frac, r, g, b, HALF_FRAC);
        fill_frac = FULL_FRAC;
      end
      acc_red   = '0;
      acc_green = '0;
      acc_blue  = '0;
      fill_frac = FULL_FRAC;
      cols_done = 0;
    end
    if (step_cols.size() > 0) begin
      tail = step_cols.pop_back();
      tail.run_last = 1'b1;
      tail.row_end  = last;
      step_cols.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want, input int col);
    if (got != want)
      report_mismatch($sformatf("column %0d %s got %0d want %0d", col, name, got, want));
  endtask

  task automatic check_column(input pix_result_t got);
    pix_result_t want;
    if (pending_cols.size() == 0) begin
      report_mismatch($sformatf("unexpected column %0d", got.column));
    end else begin
      want = pending_cols.pop_front();
      check_field("red", got.red, want.red, want.column);
      check_field("green", got.green, want.green, want.column);
      check_field("blue", got.blue, want.blue, want.column);
      check_field("out_column", got.column, want.column, want.column);
      check_field("run_last", got.run_last, want.run_last, want.column);
      check_field("row_end", got.row_end, want.row_end, want.column);
    end
  endtask

  // Drain the block, then do a two-phase register write.
  task automatic write_register(input logic [PADDR_W-3:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCALE) cfg_scale = value[SCALE_W-1:0];
    else cfg_width = value[CNT_W-1:0];
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last, input check_t chk, input pix_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    row_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    resample_pixel(r, g, b, last);
    case (chk)
      CHK_MODEL: foreach (step_cols[i]) pending_cols.push_back(step_cols[i]);
      CHK_ONE:   pending_cols.push_back(want);
      default:   ;
    endcase
  endtask

  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_rows(input int count);
    int row_len;
    while (count > 0) begin
      row_len = $urandom_range(1, 12);
      if (row_len > count) row_len = count;
      for (int k = 0; k < row_len; k++)
        send_pixel(pick_level(), pick_level(), pick_level(), k == row_len - 1,
                   CHK_MODEL, NO_COL);
      count -= row_len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      check_column({out_red, out_green, out_blue, out_column, run_last, row_end});
    out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
  end

  // Long output hold-off, counted here while the sender keeps offering.
  initial begin
    wait (hold_request);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] scale;
    logic [31:0] width;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_SCALE: write_register(REG_SCALE, directed_rows[i].value);
        ROW_WIDTH: write_register(REG_WIDTH, directed_rows[i].value);
        default:   send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                              directed_rows[i].last, directed_rows[i].chk,
                              directed_rows[i].want);
      endcase
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 52; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        case ($urandom_range(0, 9))
          0:       scale = 0;
          1:       scale = 131071;
          2, 3:    scale = $urandom_range(8193, 131071);
          default: scale = $urandom_range(1, 8192);
        endcase
        case ($urandom_range(0, 9))
          0:       width = 0;
          1:       width = 8191;
          2:       width = $urandom_range(4096, 8191);
          default: width = $urandom_range(1, 48);
        endcase
        write_register(REG_SCALE, scale);
        write_register(REG_WIDTH, width);
        send_rows(26);
      end
    end

    // Upscale into a held output so the input side backs up.
    send_idle_pct = 0;
    stall_pct = 0;
    write_register(REG_SCALE, 32'd16384);
    write_register(REG_WIDTH, 32'd64);
    hold_request = 1'b1;
    for (int k = 0; k < 20; k++)
      send_pixel(pick_level(), pick_level(), pick_level(), k == 19, CHK_MODEL, NO_COL);

    in_valid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aars_pkg.sv
hw/rtl/aars_front.sv
hw/rtl/aars_out.sv
hw/rtl/aars_back.sv
hw/rtl/area_average_row_scaler_core.sv
hw/rtl/aars_checker.sv
bench/tb_area_average_row_scaler_core.sv
